[sv/cht_pkg.sv]
`default_nettype none
package cht_pkg;

  localparam int NUM_BUCKETS_DEF = 100;
  localparam int POOL_SIZE_DEF   = 256;

  localparam int KEY_W   = 16;
  localparam int DATA_W  = 16;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int LINK_W  = 9;
  localparam int COUNT_W = 9;

  localparam logic [LINK_W-1:0] NIL_LINK = 9'd256;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;

  // free-node scan width per cycle
  localparam int GROUP   = 16;
  localparam int GROUP_W = 4;

  // key mod N by reciprocal
  localparam int HASH_SHIFT = 24;

  typedef struct packed {
    logic              take;
    logic              put;
    logic [LINK_W-1:0] put_link;
  } alloc_ctl_t;

endpackage
`default_nettype wire

[sv/cht_ram.sv]
`default_nettype none
module cht_ram #(
  parameter int WIDTH  = 9,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[sv/cht_free_alloc.sv]
`default_nettype none
module cht_free_alloc import cht_pkg::*; #(
  parameter int POOL_SIZE = POOL_SIZE_DEF,
  parameter int AW        = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  alloc_ctl_t    ctl,
  output logic [AW-1:0] free_idx,
  output logic          busy
);

  localparam int NGRP = (POOL_SIZE + GROUP - 1) / GROUP;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;

  logic [POOL_SIZE-1:0]    in_use;
  logic [NGRP*GROUP-1:0]   used_pad;
  logic [GW-1:0]           grp;
  logic [GROUP-1:0]        grp_bits;
  logic [GROUP_W-1:0]      pe;
  logic                    pe_hit;
  logic [LINK_W-1:0]       free_link;
  logic [LINK_W-1:0]       found_link;

  for (genvar i = 0; i < NGRP*GROUP; i++) begin : g_pad
    if (i < POOL_SIZE) begin : g_real
      assign used_pad[i] = in_use[i];
    end else begin : g_fill
      assign used_pad[i] = 1'b1;
    end
  end

  assign grp_bits   = used_pad[grp*GROUP +: GROUP];
  assign free_link  = LINK_W'(free_idx);
  assign found_link = LINK_W'({grp, pe});

  always_comb begin
    pe     = '0;
    pe_hit = 1'b0;
    for (int i = GROUP-1; i >= 0; i--) begin
      if (!grp_bits[i]) begin
        pe     = GROUP_W'(i);
        pe_hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use   <= '0;
      free_idx <= '0;
      busy     <= 1'b0;
      grp      <= '0;
    end else if (ctl.take) begin
      in_use[free_idx] <= 1'b1;
      grp              <= GW'(free_link >> GROUP_W);
      busy             <= 1'b1;
    end else if (ctl.put) begin
      in_use[ctl.put_link[AW-1:0]] <= 1'b0;
      // a full pool leaves free_idx on a node in use
      if (ctl.put_link < free_link || in_use[free_idx]) begin
        free_idx <= ctl.put_link[AW-1:0];
      end
    end else if (busy) begin
      if (pe_hit) begin
        free_idx <= found_link[AW-1:0];
        busy     <= 1'b0;
      end else if (32'(grp) == NGRP-1) begin
        busy <= 1'b0;
      end else begin
        grp <= grp + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[sv/chained_hash_table_top.sv]
`default_nettype none
// Key/data store: bucket = key mod NUM_BUCKETS, collisions chained through a
// pool of POOL_SIZE nodes held in synchronous RAM. One command at a time:
// S_MUL, S_QN and S_MOD hash the key and S_HEAD and S_HEADW fetch the head, then
// S_NODE visits the chain node by node (lookup/remove stop at the first key
// match, insert walks to the tail), then S_OUT loads the result word and the
// block returns to S_IDLE, where the next word is taken. An insert into a full
// pool, or an unknown command, skips S_HEADW. An insert also rescans the in-use
// map for the lowest free node, 16 nodes per cycle.
// A new word is accepted while the previous result waits on out_ready.
module chained_hash_table_top import cht_pkg::*; #(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int POOL_SIZE   = POOL_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [KEY_W-1:0]   key,
  input  logic [DATA_W-1:0]  data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STAT_W-1:0]  status,
  output logic [DATA_W-1:0]  data_out,
  output logic [COUNT_W-1:0] entry_count
);

  localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam logic [24:0] RECIP = 25'((64'd1 << HASH_SHIFT) / NUM_BUCKETS);
  localparam logic [16:0] NB17  = 17'(NUM_BUCKETS);
  localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(POOL_SIZE);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_QN    = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_HEAD  = 3'd4;
  localparam logic [2:0] S_HEADW = 3'd5;
  localparam logic [2:0] S_NODE  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]          state;
  logic [CMD_W-1:0]    cmd_r;
  logic [KEY_W-1:0]    key_r;
  logic [DATA_W-1:0]   data_r;
  logic [40:0]         prod;
  logic [16:0]         qn;
  logic [16:0]         rdiff;
  logic [16:0]         rem;
  logic [BW-1:0]       bucket;
  logic [LINK_W-1:0]   cur;
  logic [LINK_W-1:0]   prev;
  logic [STAT_W-1:0]   res_status;
  logic [DATA_W-1:0]   res_data;
  logic [COUNT_W-1:0]  count;
  logic [NUM_BUCKETS-1:0] hval;

  logic                b_we, b_re;
  logic [LINK_W-1:0]   b_wdata, b_q;
  logic                kd_we, n_re, nx_we;
  logic [AW-1:0]       kd_waddr, n_raddr, nx_waddr;
  logic [LINK_W-1:0]   nx_wdata, nx_q;
  logic [KEY_W+DATA_W-1:0] kd_q;

  alloc_ctl_t          actl;
  logic [AW-1:0]       free_idx;
  logic                alloc_busy;

  logic [LINK_W-1:0]   head;
  logic [KEY_W-1:0]    nkey;
  logic [DATA_W-1:0]   ndata;
  logic                hit;
  logic                load_out;

  assign in_ready = (state == S_IDLE);
  assign rdiff    = {1'b0, key_r} - qn;
  assign rem      = (rdiff >= NB17) ? rdiff - NB17 : rdiff;
  assign head     = hval[bucket] ? b_q : NIL_LINK;
  assign nkey     = kd_q[KEY_W+DATA_W-1:DATA_W];
  assign ndata    = kd_q[DATA_W-1:0];
  assign hit      = (nkey == key_r);
  assign load_out = (state == S_OUT) && (!out_valid || out_ready) && !alloc_busy;

  always_comb begin
    b_we     = 1'b0;
    b_re     = 1'b0;
    b_wdata  = nx_q;
    kd_we    = 1'b0;
    kd_waddr = free_idx;
    n_re     = 1'b0;
    n_raddr  = nx_q[AW-1:0];
    nx_we    = 1'b0;
    nx_waddr = free_idx;
    nx_wdata = NIL_LINK;
    actl     = '0;
    case (state)
      S_HEAD: begin
        b_re = 1'b1;
        if (cmd_r == CMD_INSERT && count != FULL_CNT) begin
          kd_we = 1'b1;
          nx_we = 1'b1;
        end
      end
      S_HEADW: begin
        if (head == NIL_LINK) begin
          if (cmd_r == CMD_INSERT) begin
            b_we      = 1'b1;
            b_wdata   = LINK_W'(free_idx);
            actl.take = 1'b1;
          end
        end else begin
          n_re    = 1'b1;
          n_raddr = head[AW-1:0];
        end
      end
      S_NODE: begin
        if (cmd_r == CMD_INSERT) begin
          if (nx_q == NIL_LINK) begin
            nx_we     = 1'b1;
            nx_waddr  = cur[AW-1:0];
            nx_wdata  = LINK_W'(free_idx);
            actl.take = 1'b1;
          end else begin
            n_re = 1'b1;
          end
        end else if (hit && cmd_r == CMD_REMOVE) begin
          if (prev == NIL_LINK) begin
            b_we = 1'b1;
          end else begin
            nx_we    = 1'b1;
            nx_waddr = prev[AW-1:0];
            nx_wdata = nx_q;
          end
          actl.put      = 1'b1;
          actl.put_link = cur;
        end else if (!hit && nx_q != NIL_LINK) begin
          n_re = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      hval      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (b_we) begin
        hval[bucket] <= 1'b1;
      end
      if (actl.take) begin
        count <= count + 1'b1;
      end
      if (actl.put && count != '0) begin
        count <= count - 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL:  state <= S_QN;
        S_QN:   state <= S_MOD;
        S_MOD:  state <= S_HEAD;
        S_HEAD: begin
          if (cmd_r == CMD_INSERT && count == FULL_CNT) begin
            state <= S_OUT;
          end else if (cmd_r != CMD_INSERT && cmd_r != CMD_LOOKUP &&
                       cmd_r != CMD_REMOVE) begin
            state <= S_OUT;
          end else begin
            state <= S_HEADW;
          end
        end
        S_HEADW: begin
          state <= (head == NIL_LINK) ? S_OUT : S_NODE;
        end
        S_NODE: begin
          if (!n_re) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd_r      <= cmd;
        key_r      <= key;
        data_r     <= data;
        res_status <= ST_NOTFOUND;
        res_data   <= '0;
      end
      S_MUL: prod   <= 41'(key_r) * 41'(RECIP);
      S_QN:  qn     <= 17'(prod[39:HASH_SHIFT] * NB17);
      S_MOD: bucket <= BW'(rem);
      S_HEAD: begin
        if (cmd_r == CMD_INSERT && count == FULL_CNT) begin
          res_status <= ST_FULL;
        end
      end
      S_HEADW: begin
        cur  <= head;
        prev <= NIL_LINK;
        if (head == NIL_LINK && cmd_r == CMD_INSERT) begin
          res_status <= ST_OK;
        end
      end
      S_NODE: begin
        prev <= cur;
        cur  <= nx_q;
        if (cmd_r == CMD_INSERT) begin
          if (nx_q == NIL_LINK) begin
            res_status <= ST_OK;
          end
        end else if (hit) begin
          res_status <= ST_OK;
          if (cmd_r == CMD_LOOKUP) begin
            res_data <= ndata;
          end
        end
      end
      S_OUT: begin
        if (load_out) begin
          status      <= res_status;
          data_out    <= res_data;
          entry_count <= count;
        end
      end
      default: begin
      end
    endcase
  end

  cht_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BUCKETS), .ADDR_W(BW)) u_head_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (bucket),
    .wdata (b_wdata),
    .re    (b_re),
    .raddr (bucket),
    .rdata (b_q)
  );

  cht_ram #(.WIDTH(KEY_W+DATA_W), .DEPTH(POOL_SIZE), .ADDR_W(AW)) u_kd_ram (
    .clk   (clk),
    .we    (kd_we),
    .waddr (kd_waddr),
    .wdata ({key_r, data_r}),
    .re    (n_re),
    .raddr (n_raddr),
    .rdata (kd_q)
  );

  cht_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SIZE), .ADDR_W(AW)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .re    (n_re),
    .raddr (n_raddr),
    .rdata (nx_q)
  );

  cht_free_alloc #(.POOL_SIZE(POOL_SIZE), .AW(AW)) u_alloc (
    .clk      (clk),
    .rst      (rst),
    .ctl      (actl),
    .free_idx (free_idx),
    .busy     (alloc_busy)
  );

endmodule
`default_nettype wire

[tb/tb_top.sv]
module tb_top;
  import cht_pkg::*;

  localparam int NB = 100;
  localparam int PS = 256;
  localparam int LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] cmd = '0;
  logic [KEY_W-1:0] key = '0;
  logic [DATA_W-1:0] data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STAT_W-1:0] status;
  logic [DATA_W-1:0] data_out;
  logic [COUNT_W-1:0] entry_count;

  chained_hash_table_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .key(key), .data(data),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .data_out(data_out), .entry_count(entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [KEY_W-1:0]  k;
    logic [DATA_W-1:0] d;
  } word_t;

  typedef struct packed {
    logic [STAT_W-1:0]  st;
    logic [DATA_W-1:0]  d;
    logic [COUNT_W-1:0] cnt;
  } reply_t;

  word_t  pending_words[$];
  reply_t expected_replies[$];

  // shadow table
  int unsigned head_of[NB];
  logic [KEY_W-1:0] nkey[PS];
  logic [DATA_W-1:0] ndata[PS];
  int unsigned nnext[PS];
  bit nused[PS];
  int unsigned nstored;

  int send_idle = 0;
  int recv_stall = 0;
  bit hold_recv = 1'b0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit done = 1'b0;
  logic [KEY_W-1:0] live_keys[$];

  function automatic reply_t table_step(word_t w);
    reply_t r;
    int unsigned b, cur, prv, n;
    r.st = ST_NOTFOUND;
    r.d = '0;
    b = w.k % NB;
    if (w.op == CMD_INSERT) begin
      n = PS;
      if (nstored < PS)
        for (int i = PS - 1; i >= 0; i--) if (!nused[i]) n = i;
      if (n == PS) r.st = ST_FULL;
      else begin
        nkey[n] = w.k; ndata[n] = w.d; nnext[n] = PS; nused[n] = 1'b1;
        if (head_of[b] >= PS) head_of[b] = n;
        else begin
          cur = head_of[b];
          while (nnext[cur] < PS) cur = nnext[cur];
          nnext[cur] = n;
        end
        nstored++;
        r.st = ST_OK;
      end
    end else if (w.op == CMD_LOOKUP) begin
      cur = head_of[b];
      while (cur < PS) begin
        if (nkey[cur] == w.k) begin
          r.st = ST_OK; r.d = ndata[cur]; break;
        end
        cur = nnext[cur];
      end
    end else if (w.op == CMD_REMOVE) begin
      prv = PS;
      cur = head_of[b];
      while (cur < PS) begin
        if (nkey[cur] == w.k) begin
          if (prv < PS) nnext[prv] = nnext[cur];
          else head_of[b] = nnext[cur];
          nused[cur] = 1'b0;
          if (nstored > 0) nstored--;
          r.st = ST_OK;
          break;
        end
        prv = cur;
        cur = nnext[cur];
      end
    end
    r.cnt = nstored[COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned m;
    m = $urandom_range(0, 9);
    if (m < 5 && live_keys.size() > 0)
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
    else if (m < 8)
      return KEY_W'($urandom_range(0, 5) * NB + $urandom_range(0, 3));
    return KEY_W'($urandom);
  endfunction

  task automatic queue_word(logic [CMD_W-1:0] op, logic [KEY_W-1:0] k,
                            logic [DATA_W-1:0] d);
    word_t w;
    w.op = op; w.k = k; w.d = d;
    pending_words.push_back(w);
    if (op == CMD_INSERT && live_keys.size() < 64) live_keys.push_back(k);
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_replies.size() > 0)
      @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        word_t w;
        w = pending_words.pop_front();
        expected_replies.push_back(table_step(w));
        in_valid <= 1'b1;
        cmd <= w.op;
        key <= w.k;
        data <= w.d;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: status %0d data %h count %0d",
                     status, data_out, entry_count);
        end else begin
          reply_t e;
          e = expected_replies.pop_front();
          if (status !== e.st || data_out !== e.d || entry_count !== e.cnt) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st %0d data %h cnt %0d, got st %0d data %h cnt %0d",
                       e.st, e.d, e.cnt, status, data_out, entry_count);
          end
        end
      end
      out_ready <= !hold_recv && ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst || done)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic random_words(int count);
    int unsigned m;
    for (int i = 0; i < count; i++) begin
      m = $urandom_range(0, 99);
      if (m < 45) queue_word(CMD_INSERT, pick_key(), DATA_W'($urandom));
      else if (m < 72) queue_word(CMD_LOOKUP, pick_key(), DATA_W'($urandom));
      else if (m < 97) queue_word(CMD_REMOVE, pick_key(), DATA_W'($urandom));
      else queue_word(2'd3, pick_key(), DATA_W'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < NB; i++) head_of[i] = PS;
    for (int i = 0; i < PS; i++) begin
      nused[i] = 1'b0; nnext[i] = PS; nkey[i] = '0; ndata[i] = '0;
    end
    nstored = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed
    queue_word(CMD_LOOKUP, 16'd0, 16'd0);
    queue_word(CMD_REMOVE, 16'hFFFF, 16'd0);
    queue_word(CMD_INSERT, 16'd0, 16'hFFFF);
    queue_word(CMD_INSERT, 16'hFFFF, 16'h0000);
    queue_word(CMD_INSERT, 16'd100, 16'h1234);
    queue_word(CMD_INSERT, 16'd200, 16'h5678);
    queue_word(CMD_INSERT, 16'd100, 16'h9ABC);
    queue_word(CMD_LOOKUP, 16'd100, 16'd0);
    queue_word(CMD_LOOKUP, 16'hFFFF, 16'd0);
    queue_word(CMD_LOOKUP, 16'd300, 16'd0);
    queue_word(CMD_REMOVE, 16'd200, 16'd0);
    queue_word(CMD_REMOVE, 16'd100, 16'd0);
    queue_word(CMD_LOOKUP, 16'd100, 16'd0);
    queue_word(CMD_REMOVE, 16'd500, 16'd0);
    queue_word(2'd3, 16'hAAAA, 16'h5555);
    queue_word(CMD_INSERT, 16'd5, 16'hA5A5);
    queue_word(CMD_LOOKUP, 16'd0, 16'd0);
    drain();

    // fill the pool, then overflow
    for (int i = 0; i < 258; i++)
      queue_word(CMD_INSERT, KEY_W'($urandom_range(0, 3) * NB + (i % 7)), DATA_W'($urandom));
    queue_word(CMD_LOOKUP, 16'd6, 16'd0);
    drain();
    for (int i = 0; i < 20; i++) queue_word(CMD_REMOVE, KEY_W'(i % 7), 16'd0);
    drain();

    send_idle = 0;   recv_stall = 0;  random_words(250); drain();
    send_idle = 76;  recv_stall = 0;  random_words(200); drain();
    send_idle = 0;   recv_stall = 76; random_words(200); drain();

    // long receiver hold-off while words keep coming
    hold_recv = 1'b1;
    random_words(30);
    repeat (400) @(posedge clk);
    hold_recv = 1'b0;
    drain();

    send_idle = 7;   recv_stall = 7;  random_words(200); drain();
    send_idle = 0;   recv_stall = 0;
    for (int i = 0; i < 20; i++) queue_word(CMD_REMOVE, pick_key(), 16'd0);
    random_words(150);
    drain();

    done = 1'b1;
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
